>>> rtl/delta_list_task_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delta-list task scheduler
// Concurrent property helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TASK_SCHEDULER_UNIT_MACROS_SVH
`define DELTA_LIST_TASK_SCHEDULER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define DLTS_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("dlts: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define DLTS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("dlts: next-cycle check failed");

`else

`define DLTS_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons)
`define DLTS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

>>> rtl/dlts_pkg.sv
// ----------------------------------------------------------------------------
// Delta-list task scheduler package
// Field widths, operation and status codes, and the result beat type.
// ----------------------------------------------------------------------------
package dlts_pkg;

  localparam int KIND_W    = 2;
  localparam int ID_W      = 4;
  localparam int IN_TIME_W = 16;
  localparam int PEND_W    = 8;
  localparam int STATUS_W  = 2;

  localparam logic [PEND_W-1:0] PEND_MAX = 8'd255;

  // Operation codes carried by the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 2'd0,
    KIND_ADD      = 2'd1,
    KIND_DISPATCH = 2'd2
  } kind_t;

  // Completion status of one operation
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_t;

  // One result beat
  typedef struct packed {
    logic            ran;
    logic [ID_W-1:0] ran_task_id;
    status_t         status;
  } res_t;

endpackage

>>> rtl/dlts_in_if.sv
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel carrying one operation request per beat.
// ----------------------------------------------------------------------------
interface dlts_in_if;

  logic                           valid;
  logic                           ready;
  logic [dlts_pkg::KIND_W-1:0]    kind;
  logic [dlts_pkg::ID_W-1:0]      task_id;
  logic [dlts_pkg::IN_TIME_W-1:0] first_delay;
  logic [dlts_pkg::IN_TIME_W-1:0] repeat_period;

  modport source (
    output valid, kind, task_id, first_delay, repeat_period,
    input  ready
  );

  modport sink (
    input  valid, kind, task_id, first_delay, repeat_period,
    output ready
  );

endinterface

>>> rtl/dlts_out_if.sv
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface dlts_out_if;

  logic                          valid;
  logic                          ready;
  logic                          ran;
  logic [dlts_pkg::ID_W-1:0]     ran_task_id;
  logic [dlts_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, ran, ran_task_id, status,
    input  ready
  );

  modport sink (
    input  valid, ran, ran_task_id, status,
    output ready
  );

endinterface

>>> rtl/dlts_resp_reg.sv
// ----------------------------------------------------------------------------
// Scheduler result register
// Holds one finished result beat until the downstream side takes it, so the
// scheduler core can start on the next request meanwhile.
// ----------------------------------------------------------------------------
module dlts_resp_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  dlts_pkg::res_t    res,
  output logic              can_load,
  dlts_out_if.source        out_bus
);

  logic           valid_r;
  dlts_pkg::res_t data_r;

  // Free when empty or when the held beat leaves this cycle
  assign can_load = !valid_r || out_bus.ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_bus.valid       = valid_r;
  assign out_bus.ran         = data_r.ran;
  assign out_bus.ran_task_id = data_r.ran_task_id;
  assign out_bus.status      = data_r.status;

endmodule

>>> rtl/delta_list_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Delta-list task scheduler
// Periodic task entries kept in due order in a slot memory as a linked list.
// ----------------------------------------------------------------------------
// One request is worked on at a time and each request gives one result beat.
// A tick reads and then writes the head entry, or goes straight to its result
// on an empty list. A rejected add, an unused kind or a dispatch on an empty
// list also goes straight to its result, and a dispatch whose head has nothing
// pending stops after reading that head. An add that places an entry, or a
// dispatch that releases the head, walks the list one entry per cycle, each
// step being one access of the slot memory (a read and a write never share a
// cycle), followed by up to two entry writes. Each result leaves through an
// output register and waits while that register stays full. A new request is
// accepted while the previous result still waits in the output register. No
// clearing pass is needed after reset.
module delta_list_task_scheduler_unit #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  dlts_in_if.sink     in_bus,
  dlts_out_if.source  out_bus
);

  `include "delta_list_task_scheduler_unit_macros.svh"

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int LINK_W = $clog2(MAX_TASKS + 1);
  localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(MAX_TASKS);

  typedef struct packed {
    logic [dlts_pkg::ID_W-1:0]   task_id;
    logic [TIME_BITS-1:0]        delta;
    logic [TIME_BITS-1:0]        period;
    logic [dlts_pkg::PEND_W-1:0] pending;
    logic [LINK_W-1:0]           link;
  } slot_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_TICK   = 9'b000000010,
    ST_DCHK   = 9'b000000100,
    ST_LSTART = 9'b000001000,
    ST_LHEAD  = 9'b000010000,
    ST_LWALK  = 9'b000100000,
    ST_LWS    = 9'b001000000,
    ST_LWC    = 9'b010000000,
    ST_RESP   = 9'b100000000
  } state_t;

  // Control state
  state_t            state_r, state_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] used_cnt_r, used_cnt_nxt;

  // Working registers of the insertion walk
  logic [SLOT_W-1:0]           s_slot_r, s_slot_nxt;
  logic [dlts_pkg::ID_W-1:0]   s_task_r, s_task_nxt;
  logic [TIME_BITS-1:0]        s_period_r, s_period_nxt;
  logic [TIME_BITS-1:0]        t_r, t_nxt;
  logic [SLOT_W-1:0]           cur_r, cur_nxt;
  slot_t                       cur_ent_r, cur_ent_nxt;
  logic [LINK_W-1:0]           nxt_r, nxt_nxt;
  logic                        fix_cur_r, fix_cur_nxt;
  dlts_pkg::res_t              res_r, res_nxt;

  // Slot memory ports
  slot_t             slot_mem [MAX_TASKS];
  slot_t             rd_data_r;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_t             wr_data;

  logic                 res_load;
  logic                 res_can_load;
  logic                 in_fire;
  logic [TIME_BITS-1:0] in_delay;
  logic [TIME_BITS-1:0] in_period;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign in_delay     = TIME_BITS'(in_bus.first_delay);
  assign in_period    = TIME_BITS'(in_bus.repeat_period);

  // Slot memory: one write and one read port, read data registered,
  // a same-address write forwarded to the read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= slot_mem[rd_addr];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    used_cnt_nxt = used_cnt_r;
    s_slot_nxt   = s_slot_r;
    s_task_nxt   = s_task_r;
    s_period_nxt = s_period_r;
    t_nxt        = t_r;
    cur_nxt      = cur_r;
    cur_ent_nxt  = cur_ent_r;
    nxt_nxt      = nxt_r;
    fix_cur_nxt  = fix_cur_r;
    res_nxt      = res_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = rd_data_r;
    res_load     = 1'b0;

    case (state_r)
      // Accept a request and start its first access
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt.ran         = 1'b0;
          res_nxt.ran_task_id = '0;
          res_nxt.status      = dlts_pkg::STAT_OK;
          case (in_bus.kind)
            dlts_pkg::KIND_TICK: begin
              if (head_r == NO_SLOT) begin
                state_nxt = ST_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r[SLOT_W-1:0];
                state_nxt = ST_TICK;
              end
            end
            dlts_pkg::KIND_ADD: begin
              if (used_cnt_r == NO_SLOT) begin
                res_nxt.status = dlts_pkg::STAT_FULL;
                state_nxt      = ST_RESP;
              end else begin
                // Slots are never freed, so the next free slot is the count
                s_slot_nxt   = used_cnt_r[SLOT_W-1:0];
                used_cnt_nxt = used_cnt_r + LINK_W'(1);
                s_task_nxt   = in_bus.task_id;
                s_period_nxt = in_period;
                t_nxt        = in_delay;
                state_nxt    = ST_LSTART;
              end
            end
            dlts_pkg::KIND_DISPATCH: begin
              if (head_r == NO_SLOT) begin
                res_nxt.status = dlts_pkg::STAT_NONE;
                state_nxt      = ST_RESP;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head_r[SLOT_W-1:0];
                s_slot_nxt = head_r[SLOT_W-1:0];
                state_nxt  = ST_DCHK;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      // Count down the head, or mark it due and reload from its period
      ST_TICK: begin
        wr_en   = 1'b1;
        wr_addr = head_r[SLOT_W-1:0];
        if (rd_data_r.delta > TIME_BITS'(1)) begin
          wr_data.delta = rd_data_r.delta - TIME_BITS'(1);
        end else begin
          if (rd_data_r.pending != dlts_pkg::PEND_MAX) begin
            wr_data.pending = rd_data_r.pending + dlts_pkg::PEND_W'(1);
          end
          wr_data.delta = rd_data_r.period;
        end
        state_nxt = ST_RESP;
      end

      // Release a pending head: unlink it and reinsert by its delta; else report none
      ST_DCHK: begin
        if (rd_data_r.pending == '0) begin
          res_nxt.status = dlts_pkg::STAT_NONE;
          state_nxt      = ST_RESP;
        end else begin
          res_nxt.ran         = 1'b1;
          res_nxt.ran_task_id = rd_data_r.task_id;
          head_nxt            = rd_data_r.link;
          s_task_nxt          = rd_data_r.task_id;
          s_period_nxt        = rd_data_r.period;
          t_nxt               = rd_data_r.delta;
          state_nxt           = ST_LSTART;
        end
      end

      // Insert into an empty list, or fetch the head
      ST_LSTART: begin
        if (head_r == NO_SLOT) begin
          nxt_nxt     = NO_SLOT;
          fix_cur_nxt = 1'b0;
          head_nxt    = LINK_W'(s_slot_r);
          state_nxt   = ST_LWS;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head_r[SLOT_W-1:0];
          state_nxt = ST_LHEAD;
        end
      end

      // Go in front of the head, or step past it
      ST_LHEAD: begin
        if (t_r < rd_data_r.delta) begin
          wr_en         = 1'b1;
          wr_addr       = head_r[SLOT_W-1:0];
          wr_data.delta = rd_data_r.delta - t_r;
          nxt_nxt       = head_r;
          head_nxt      = LINK_W'(s_slot_r);
          fix_cur_nxt   = 1'b0;
          state_nxt     = ST_LWS;
        end else begin
          t_nxt       = t_r - rd_data_r.delta;
          cur_nxt     = head_r[SLOT_W-1:0];
          cur_ent_nxt = rd_data_r;
          nxt_nxt     = rd_data_r.link;
          fix_cur_nxt = 1'b1;
          if (rd_data_r.link == NO_SLOT) begin
            state_nxt = ST_LWS;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = rd_data_r.link[SLOT_W-1:0];
            state_nxt = ST_LWALK;
          end
        end
      end

      // Advance while the next entry is due strictly earlier
      ST_LWALK: begin
        if (rd_data_r.delta < t_r) begin
          cur_nxt     = nxt_r[SLOT_W-1:0];
          cur_ent_nxt = rd_data_r;
          t_nxt       = t_r - rd_data_r.delta;
          nxt_nxt     = rd_data_r.link;
          if (rd_data_r.link == NO_SLOT) begin
            state_nxt = ST_LWS;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_data_r.link[SLOT_W-1:0];
          end
        end else begin
          // The follower alone gives up the new entry's delta
          wr_en         = 1'b1;
          wr_addr       = nxt_r[SLOT_W-1:0];
          wr_data.delta = rd_data_r.delta - t_r;
          state_nxt     = ST_LWS;
        end
      end

      // Write the placed entry
      ST_LWS: begin
        wr_en           = 1'b1;
        wr_addr         = s_slot_r;
        wr_data.task_id = s_task_r;
        wr_data.delta   = t_r;
        wr_data.period  = s_period_r;
        wr_data.pending = '0;
        wr_data.link    = nxt_r;
        state_nxt       = fix_cur_r ? ST_LWC : ST_RESP;
      end

      // Point the predecessor at the placed entry
      ST_LWC: begin
        wr_en        = 1'b1;
        wr_addr      = cur_r;
        wr_data      = cur_ent_r;
        wr_data.link = LINK_W'(s_slot_r);
        state_nxt    = ST_RESP;
      end

      // Hand the result to the output register
      ST_RESP: begin
        if (res_can_load) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      head_r     <= NO_SLOT;
      used_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      used_cnt_r <= used_cnt_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    s_slot_r   <= s_slot_nxt;
    s_task_r   <= s_task_nxt;
    s_period_r <= s_period_nxt;
    t_r        <= t_nxt;
    cur_r      <= cur_nxt;
    cur_ent_r  <= cur_ent_nxt;
    nxt_r      <= nxt_nxt;
    fix_cur_r  <= fix_cur_nxt;
    res_r      <= res_nxt;
  end

  // Result register toward the output channel
  dlts_resp_reg u_resp_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_load),
    .res      (res_r),
    .can_load (res_can_load),
    .out_bus  (out_bus)
  );

  // Checks
  `DLTS_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_fire, state_r != ST_IDLE)
  `DLTS_ASSERT_IMPLY(a_head_matches_count, clk, rst_n, state_r == ST_IDLE, (head_r == NO_SLOT) == (used_cnt_r == '0))
  `DLTS_ASSERT_IMPLY(a_write_allocated_slot, clk, rst_n, wr_en, LINK_W'(wr_addr) < used_cnt_r)

endmodule
